@@ design/lcd_pkg.sv @@
package lcd_pkg;

    localparam int LINE_CAPACITY_DEFAULT = 32;

    localparam int WORD_COUNT = 4;

    // Command word slots, in decode priority order
    localparam logic [1:0] WORD_LED_ON  = 2'd0;
    localparam logic [1:0] WORD_LED_OFF = 2'd1;
    localparam logic [1:0] WORD_STATUS  = 2'd2;
    localparam logic [1:0] WORD_HELP    = 2'd3;

    // Response codes
    localparam logic [2:0] RESP_NONE        = 3'd0;
    localparam logic [2:0] RESP_LED_ON_OK   = 3'd1;
    localparam logic [2:0] RESP_LED_OFF_OK  = 3'd2;
    localparam logic [2:0] RESP_STATUS_LIT  = 3'd3;
    localparam logic [2:0] RESP_STATUS_DARK = 3'd4;
    localparam logic [2:0] RESP_HELP        = 3'd5;
    localparam logic [2:0] RESP_UNKNOWN     = 3'd6;

    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_UPPER_A = 8'd65;

    typedef struct packed {
        logic [7:0] rx_char;
    } in_t;

    typedef struct packed {
        logic [7:0] echo_char;
        logic [2:0] response;
        logic       led_lit;
    } out_t;

    function automatic logic [2:0] word_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            WORD_LED_ON:  len = 3'd6;
            WORD_LED_OFF: len = 3'd7;
            WORD_STATUS:  len = 3'd6;
            WORD_HELP:    len = 3'd4;
            default:      len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            WORD_LED_ON:
            begin
                unique case (pos)
                    3'd0:    c = "L";
                    3'd1:    c = "E";
                    3'd2:    c = "D";
                    3'd3:    c = " ";
                    3'd4:    c = "O";
                    3'd5:    c = "N";
                    default: c = 8'h00;
                endcase
            end
            WORD_LED_OFF:
            begin
                unique case (pos)
                    3'd0:    c = "L";
                    3'd1:    c = "E";
                    3'd2:    c = "D";
                    3'd3:    c = " ";
                    3'd4:    c = "O";
                    3'd5:    c = "F";
                    3'd6:    c = "F";
                    default: c = 8'h00;
                endcase
            end
            WORD_STATUS:
            begin
                unique case (pos)
                    3'd0:    c = "S";
                    3'd1:    c = "T";
                    3'd2:    c = "A";
                    3'd3:    c = "T";
                    3'd4:    c = "U";
                    3'd5:    c = "S";
                    default: c = 8'h00;
                endcase
            end
            WORD_HELP:
            begin
                unique case (pos)
                    3'd0:    c = "H";
                    3'd1:    c = "E";
                    3'd2:    c = "L";
                    3'd3:    c = "P";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ design/lcd_stream_if.sv @@
interface lcd_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/line_command_decoder.sv @@
// Results are registered: into the result register, or into the skid register on a stall.
// Throughput: one character per cycle while the output side takes results.
// A two-entry output stage (result register plus skid register) lets one more transaction
// in while a result waits; ready drops only when both entries are full.
// Reset (rst_n, asynchronous, active low): empty line, all commands possible, LED dark,
// output stage empty.
module line_command_decoder #(
    parameter int LINE_CAPACITY = lcd_pkg::LINE_CAPACITY_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    lcd_stream_if.sink   rx,
    lcd_stream_if.source tx
);

    // Enough bits to hold LINE_CAPACITY - 1
    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

    // Line state
    logic [LEN_W-1:0]                  line_length_reg, line_length_next;
    logic [lcd_pkg::WORD_COUNT-1:0]    cand_reg, cand_next;
    logic                              led_reg, led_next;

    // Output stage
    lcd_pkg::out_t out_reg, skid_reg;
    logic          out_valid_reg, skid_valid_reg;

    logic          push, pop;
    logic          is_term;
    logic [7:0]    ch, up;
    logic [lcd_pkg::WORD_COUNT-1:0] hit;
    logic [2:0]    resp;
    lcd_pkg::out_t result;

    // Accept whenever the skid entry is free
    assign rx.ready = !skid_valid_reg;
    assign push     = rx.valid && rx.ready;
    assign pop      = out_valid_reg && tx.ready;

    assign tx.valid = out_valid_reg;
    assign tx.data  = out_reg;

    assign ch      = rx.data.rx_char;
    assign is_term = (ch == lcd_pkg::CH_CR) || (ch == lcd_pkg::CH_LF);

    // Fold lower case to upper case
    always_comb
    begin
        up = ch;
        if (ch >= lcd_pkg::CH_LOWER_A && ch <= lcd_pkg::CH_LOWER_Z)
        begin
            up = ch - (lcd_pkg::CH_LOWER_A - lcd_pkg::CH_UPPER_A);
        end
    end

    // A command matches when its flag survived and the line has exactly its length
    always_comb
    begin
        for (int k = 0; k < lcd_pkg::WORD_COUNT; k++)
        begin
            hit[k] = cand_reg[k] &&
                     (line_length_reg == LEN_W'(lcd_pkg::word_len(2'(k))));
        end
    end

    // Next line state and the response for this character
    always_comb
    begin
        line_length_next = line_length_reg;
        cand_next        = cand_reg;
        led_next         = led_reg;
        resp             = lcd_pkg::RESP_NONE;

        if (is_term)
        begin
            // Empty line: no response, nothing changes
            if (line_length_reg != '0)
            begin
                priority if (hit[lcd_pkg::WORD_LED_ON])
                begin
                    led_next = 1'b1;
                    resp     = lcd_pkg::RESP_LED_ON_OK;
                end
                else if (hit[lcd_pkg::WORD_LED_OFF])
                begin
                    led_next = 1'b0;
                    resp     = lcd_pkg::RESP_LED_OFF_OK;
                end
                else if (hit[lcd_pkg::WORD_STATUS])
                begin
                    resp = led_reg ? lcd_pkg::RESP_STATUS_LIT : lcd_pkg::RESP_STATUS_DARK;
                end
                else if (hit[lcd_pkg::WORD_HELP])
                begin
                    resp = lcd_pkg::RESP_HELP;
                end
                else
                begin
                    resp = lcd_pkg::RESP_UNKNOWN;
                end
                line_length_next = '0;
                cand_next        = '1;
            end
        end
        else if (line_length_reg < LEN_MAX)
        begin
            // Store the character: drop every word it does not continue
            for (int k = 0; k < lcd_pkg::WORD_COUNT; k++)
            begin
                if (!((line_length_reg < LEN_W'(lcd_pkg::word_len(2'(k)))) &&
                      (lcd_pkg::word_char(2'(k), line_length_reg[2:0]) == up)))
                begin
                    cand_next[k] = 1'b0;
                end
            end
            line_length_next = line_length_reg + LEN_W'(1);
        end
        // Line full: echo but drop the character
    end

    always_comb
    begin
        result.echo_char = ch;
        result.response  = resp;
        result.led_lit   = led_next;
    end

    // Advance line state only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= '0;
            cand_reg        <= '1;
            led_reg         <= 1'b0;
        end
        else if (push)
        begin
            line_length_reg <= line_length_next;
            cand_reg        <= cand_next;
            led_reg         <= led_next;
        end
    end

    // Output stage control: fill the result register first, spill to skid on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

`ifndef ASSERT_OFF
    // Skid entry is only ever the second of two held results
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while result register empty");

    // Line length never passes capacity minus one
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_length_reg <= LEN_MAX)
        else $error("line length past capacity");

    // A terminator always leaves an empty line with every command possible
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && is_term) |=> (line_length_reg == '0 && cand_reg == '1))
        else $error("terminator did not clear the line");

    // LED ON response lights the LED
    a_led_on: assert property (@(posedge clk) disable iff (!rst_n)
        (push && resp == lcd_pkg::RESP_LED_ON_OK) |=> led_reg)
        else $error("LED ON did not light the LED");

    // Response only on a terminator of a non-empty line
    a_resp_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        (push && resp != lcd_pkg::RESP_NONE) |-> (is_term && line_length_reg != '0))
        else $error("response outside a line terminator");
`endif

endmodule
